### src/gsm_pkg.sv
`default_nettype none

package gsm_pkg;

	localparam int WINDOW_DEPTH = 10;
	localparam int SAMPLE_WIDTH = 16;

	localparam int LIM_W    = 15;
	localparam int MIN_W    = 16;
	localparam int CNT_W    = 16;
	localparam int IDX_W    = $clog2(WINDOW_DEPTH);
	localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
	localparam int RANK_W   = IDX_W;
	localparam int CMP_W    = (SAMPLE_WIDTH + 2 > LIM_W + 1) ? SAMPLE_WIDTH + 2 : LIM_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 16;

	localparam int OUTL_MIN_FILL = 3;

	localparam logic [LIM_W-1:0] RANGE_RESET = LIM_W'(10000);
	localparam logic [LIM_W-1:0] THR_RESET   = LIM_W'(2000);
	localparam logic [MIN_W-1:0] MIN_RESET   = MIN_W'(5);

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DET     = 2'd2;

	localparam logic [1:0] STAT_ACCEPTED = 2'd0;
	localparam logic [1:0] STAT_FAR      = 2'd1;
	localparam logic [1:0] STAT_OUTLIER  = 2'd2;
	localparam logic [1:0] STAT_CLEARED  = 2'd3;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef sample_t axes_t [3];
	typedef logic [RANK_W-1:0] rank_t;
	typedef rank_t ranks_t [3];

	typedef struct packed {
		logic shift;
		logic load;
		logic rotate;
	} cell_ctrl_t;

	typedef struct packed {
		logic far;
		logic outl;
	} gate_t;

endpackage

`default_nettype wire

### src/gsm_cell.sv
`default_nettype none

module gsm_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gsm_pkg::cell_ctrl_t        ctrl,
	input  logic [gsm_pkg::IDX_W-1:0]  idx,
	input  logic                       valid,
	input  gsm_pkg::axes_t             shift_in,
	input  gsm_pkg::axes_t             ring_in,
	input  logic [gsm_pkg::IDX_W-1:0]  ring_idx_in,
	input  logic                       ring_vld_in,
	output gsm_pkg::axes_t             val_out,
	output gsm_pkg::axes_t             ring_out,
	output logic [gsm_pkg::IDX_W-1:0]  ring_idx_out,
	output logic                       ring_vld_out,
	output gsm_pkg::ranks_t            rank
);

	gsm_pkg::axes_t             val_q;
	gsm_pkg::axes_t             ring_q;
	logic [gsm_pkg::IDX_W-1:0]  ring_idx_q;
	logic                       ring_vld_q;
	gsm_pkg::ranks_t            rank_q;
	logic [2:0]                 below;

	// ring entry ranks below this cell: smaller, or equal and a lower slot index
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			below[k] = ring_vld_q && ((ring_q[k] < val_q[k]) ||
				((ring_q[k] == val_q[k]) && (ring_idx_q < idx)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= 1'b0;
		end else if (ctrl.load) begin
			ring_vld_q <= valid;
		end else if (ctrl.rotate) begin
			ring_vld_q <= ring_vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q <= shift_in;
		end
		if (ctrl.load) begin
			ring_q     <= val_q;
			ring_idx_q <= idx;
			rank_q     <= '{default: '0};
		end else if (ctrl.rotate) begin
			ring_q     <= ring_in;
			ring_idx_q <= ring_idx_in;
			for (int k = 0; k < 3; k++) begin
				rank_q[k] <= rank_q[k] + gsm_pkg::RANK_W'(below[k]);
			end
		end
	end

	assign val_out      = val_q;
	assign ring_out     = ring_q;
	assign ring_idx_out = ring_idx_q;
	assign ring_vld_out = ring_vld_q;
	assign rank         = rank_q;

endmodule

`default_nettype wire

### src/gsm_gate.sv
`default_nettype none

module gsm_gate (
	input  gsm_pkg::axes_t              samp,
	input  gsm_pkg::axes_t              med,
	input  logic [gsm_pkg::LIM_W-1:0]   range_limit,
	input  logic [gsm_pkg::LIM_W-1:0]   threshold,
	input  logic                        check_outl,
	output gsm_pkg::gate_t              gate
);

	logic signed [gsm_pkg::CMP_W-1:0] s_ext [3];
	logic signed [gsm_pkg::CMP_W-1:0] diff  [3];
	logic [gsm_pkg::CMP_W-1:0]        s_mag [3];
	logic [gsm_pkg::CMP_W-1:0]        d_mag [3];
	logic [2:0]                       far_ax;
	logic [2:0]                       outl_ax;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			s_ext[k]   = gsm_pkg::CMP_W'(samp[k]);
			diff[k]    = s_ext[k] - gsm_pkg::CMP_W'(med[k]);
			s_mag[k]   = s_ext[k][gsm_pkg::CMP_W-1] ? -s_ext[k] : s_ext[k];
			d_mag[k]   = diff[k][gsm_pkg::CMP_W-1] ? -diff[k] : diff[k];
			far_ax[k]  = s_mag[k] > gsm_pkg::CMP_W'(range_limit);
			outl_ax[k] = d_mag[k] > gsm_pkg::CMP_W'(threshold);
		end
		gate.far  = |far_ax;
		gate.outl = check_outl && (|outl_ax);
	end

endmodule

`default_nettype wire

### src/gsm_select.sv
`default_nettype none

module gsm_select (
	input  gsm_pkg::axes_t               vals  [gsm_pkg::WINDOW_DEPTH],
	input  gsm_pkg::ranks_t              ranks [gsm_pkg::WINDOW_DEPTH],
	input  logic [gsm_pkg::WINDOW_DEPTH-1:0] vld,
	input  logic [gsm_pkg::FILL_W-1:0]   fill,
	output gsm_pkg::axes_t               med
);

	logic [gsm_pkg::RANK_W-1:0]           lo_rank;
	logic [gsm_pkg::RANK_W-1:0]           hi_rank;
	gsm_pkg::axes_t                       lo_val;
	gsm_pkg::axes_t                       hi_val;
	logic signed [gsm_pkg::SAMPLE_WIDTH:0] sum [3];

	// odd fill: both middle ranks coincide, so the halved sum is the value itself
	always_comb begin
		lo_rank = gsm_pkg::RANK_W'((fill - 1'b1) >> 1);
		hi_rank = gsm_pkg::RANK_W'(fill >> 1);
		for (int k = 0; k < 3; k++) begin
			lo_val[k] = '0;
			hi_val[k] = '0;
			for (int j = 0; j < gsm_pkg::WINDOW_DEPTH; j++) begin
				if (vld[j] && (ranks[j][k] == lo_rank)) begin
					lo_val[k] = lo_val[k] | vals[j][k];
				end
				if (vld[j] && (ranks[j][k] == hi_rank)) begin
					hi_val[k] = hi_val[k] | vals[j][k];
				end
			end
			sum[k] = (gsm_pkg::SAMPLE_WIDTH + 1)'(lo_val[k]) +
				(gsm_pkg::SAMPLE_WIDTH + 1)'(hi_val[k]);
			med[k] = sum[k][gsm_pkg::SAMPLE_WIDTH:1];
		end
	end

endmodule

`default_nettype wire

### src/gated_sliding_median_filter.sv
// gated sliding median filter for 3-axis target positions
// input channel: in_valid / in_stall carry one request, either a clear (kind=1)
//   or a signed position sample (sample_x/y/z, millimetres)
// output channel: out_valid / out_stall carry one result per request: status,
//   held medians, window fill, detection count and confirmed flag
// configuration: cfg_we writes cfg_data to register cfg_index (0 range limit,
//   1 outlier threshold, 2 minimum detections); other indexes are ignored
// path from accept to out_valid: an accepted sample passes the gate, load, rank,
//   select and done states; a rejection or a clear goes from gate straight to done
// throughput: one request at a time; in_stall stays high until the request
//   has reached the output register; the ranking pass rotates the window once
//   around the chain of cells, one position per cycle
// the output register holds a finished result while the next request is
//   taken and processed; out_stall only delays loading the following result
// reset: window empty, count zero, medians zero, registers at defaults;
//   no clearing pass is needed
`default_nettype none

module gated_sliding_median_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  gsm_pkg::sample_t                    sample_x,
	input  gsm_pkg::sample_t                    sample_y,
	input  gsm_pkg::sample_t                    sample_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output gsm_pkg::sample_t                    median_x,
	output gsm_pkg::sample_t                    median_y,
	output gsm_pkg::sample_t                    median_z,
	output logic [gsm_pkg::FILL_W-1:0]          window_fill,
	output logic [gsm_pkg::CNT_W-1:0]           detections,
	output logic                                confirmed,
	input  logic                                cfg_we,
	input  logic [gsm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gsm_pkg::CFG_W-1:0]           cfg_data
);

	localparam int WD = gsm_pkg::WINDOW_DEPTH;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_GATE = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_RANK = 3'd3;
	localparam logic [2:0] S_SEL  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	// configuration registers
	logic [gsm_pkg::LIM_W-1:0]  range_q;
	logic [gsm_pkg::LIM_W-1:0]  thr_q;
	logic [gsm_pkg::MIN_W-1:0]  min_det_q;

	// sequencer and filter state
	logic [2:0]                 state_q;
	logic [gsm_pkg::IDX_W-1:0]  cnt_q;
	logic                       kind_q;
	gsm_pkg::axes_t             samp_q;
	logic [gsm_pkg::FILL_W-1:0] fill_q;
	logic [gsm_pkg::CNT_W-1:0]  acc_q;
	logic                       det_q;
	logic [1:0]                 status_q;
	gsm_pkg::axes_t             held_q;

	// output register
	logic                       ovalid_q;
	logic [1:0]                 ostatus_q;
	gsm_pkg::axes_t             omed_q;
	logic [gsm_pkg::FILL_W-1:0] ofill_q;
	logic [gsm_pkg::CNT_W-1:0]  odet_q;
	logic                       oconf_q;

	logic                       in_take;
	logic                       out_free;
	gsm_pkg::cell_ctrl_t        ctrl;
	gsm_pkg::gate_t             gate;
	gsm_pkg::axes_t             sel_med;

	// chain wiring
	gsm_pkg::axes_t             cell_val  [WD];
	gsm_pkg::axes_t             ring_val  [WD];
	logic [gsm_pkg::IDX_W-1:0]  ring_idx  [WD];
	logic [WD-1:0]              ring_vld;
	gsm_pkg::ranks_t            cell_rank [WD];
	logic [WD-1:0]              cell_vld;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !ovalid_q || !out_stall;

	// cell control: shift on an accepted sample, then load and rotate the ring
	always_comb begin
		ctrl.shift  = (state_q == S_GATE) && !kind_q && !gate.far && !gate.outl;
		ctrl.load   = (state_q == S_LOAD);
		ctrl.rotate = (state_q == S_RANK);
	end

	gsm_gate u_gate (
		.samp        (samp_q),
		.med         (held_q),
		.range_limit (range_q),
		.threshold   (thr_q),
		.check_outl  (fill_q >= gsm_pkg::FILL_W'(gsm_pkg::OUTL_MIN_FILL)),
		.gate        (gate)
	);

	// newest sample enters cell 0; cell WD-1 holds the oldest, which falls off
	for (genvar j = 0; j < WD; j++) begin : g_cell
		assign cell_vld[j] = (gsm_pkg::FILL_W'(j) < fill_q);

		if (j == 0) begin : g_head
			gsm_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (ctrl),
				.idx          (gsm_pkg::IDX_W'(j)),
				.valid        (cell_vld[j]),
				.shift_in     (samp_q),
				.ring_in      (ring_val[WD-1]),
				.ring_idx_in  (ring_idx[WD-1]),
				.ring_vld_in  (ring_vld[WD-1]),
				.val_out      (cell_val[j]),
				.ring_out     (ring_val[j]),
				.ring_idx_out (ring_idx[j]),
				.ring_vld_out (ring_vld[j]),
				.rank         (cell_rank[j])
			);
		end else begin : g_body
			gsm_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (ctrl),
				.idx          (gsm_pkg::IDX_W'(j)),
				.valid        (cell_vld[j]),
				.shift_in     (cell_val[j-1]),
				.ring_in      (ring_val[j-1]),
				.ring_idx_in  (ring_idx[j-1]),
				.ring_vld_in  (ring_vld[j-1]),
				.val_out      (cell_val[j]),
				.ring_out     (ring_val[j]),
				.ring_idx_out (ring_idx[j]),
				.ring_vld_out (ring_vld[j]),
				.rank         (cell_rank[j])
			);
		end
	end

	gsm_select u_select (
		.vals  (cell_val),
		.ranks (cell_rank),
		.vld   (cell_vld),
		.fill  (fill_q),
		.med   (sel_med)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q   <= gsm_pkg::RANGE_RESET;
			thr_q     <= gsm_pkg::THR_RESET;
			min_det_q <= gsm_pkg::MIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				gsm_pkg::REG_RANGE_LIMIT: range_q   <= cfg_data[gsm_pkg::LIM_W-1:0];
				gsm_pkg::REG_OUTLIER_THR: thr_q     <= cfg_data[gsm_pkg::LIM_W-1:0];
				gsm_pkg::REG_MIN_DET:     min_det_q <= cfg_data[gsm_pkg::MIN_W-1:0];
				default: ;
			endcase
		end
	end

	// request payload capture
	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_q    <= kind;
			samp_q[0] <= sample_x;
			samp_q[1] <= sample_y;
			samp_q[2] <= sample_z;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			fill_q   <= '0;
			acc_q    <= '0;
			det_q    <= 1'b0;
			status_q <= gsm_pkg::STAT_ACCEPTED;
			held_q   <= '{default: '0};
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_GATE;
					end
				end
				S_GATE: begin
					if (kind_q) begin
						fill_q   <= '0;
						acc_q    <= '0;
						det_q    <= 1'b0;
						status_q <= gsm_pkg::STAT_CLEARED;
						state_q  <= S_DONE;
					end else if (gate.far) begin
						status_q <= gsm_pkg::STAT_FAR;
						state_q  <= S_DONE;
					end else if (gate.outl) begin
						status_q <= gsm_pkg::STAT_OUTLIER;
						state_q  <= S_DONE;
					end else begin
						if (fill_q != gsm_pkg::FILL_W'(WD)) begin
							fill_q <= fill_q + 1'b1;
						end
						if (acc_q != '1) begin
							acc_q <= acc_q + 1'b1;
						end
						det_q    <= 1'b1;
						status_q <= gsm_pkg::STAT_ACCEPTED;
						state_q  <= S_LOAD;
					end
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_RANK;
				end
				S_RANK: begin
					// one rotation step per cycle, a full turn ranks every pair
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == gsm_pkg::IDX_W'(WD - 1)) begin
						state_q <= S_SEL;
					end
				end
				S_SEL: begin
					held_q  <= sel_med;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			ovalid_q <= 1'b1;
		end else if (!out_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			ostatus_q <= status_q;
			omed_q    <= held_q;
			ofill_q   <= fill_q;
			odet_q    <= acc_q;
			oconf_q   <= det_q && (acc_q >= min_det_q);
		end
	end

	assign out_valid   = ovalid_q;
	assign status      = ostatus_q;
	assign median_x    = omed_q[0];
	assign median_y    = omed_q[1];
	assign median_z    = omed_q[2];
	assign window_fill = ofill_q;
	assign detections  = odet_q;
	assign confirmed   = oconf_q;

	// a taken request always starts the gate step
	assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == S_GATE))
		else $error("request taken but gate step not entered");

	// an accepted sample always leaves the window non-empty
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.shift |=> (fill_q != '0))
		else $error("window empty after accepted sample");

	// median selection only runs on a populated window
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEL) |-> ((fill_q != '0) && (fill_q <= gsm_pkg::FILL_W'(WD))))
		else $error("median selection with bad fill");

	// detection flag and count move together
	assert property (@(posedge clk) disable iff (!arst_n)
		!det_q |-> (acc_q == '0))
		else $error("detection count without detection flag");

endmodule

`default_nettype wire

### test/gated_sliding_median_filter_tb.sv
`timescale 1ns / 1ps

module gated_sliding_median_filter_tb;

	// timing of the run
	localparam int STUCK_LIMIT   = 2000;  // cycles with no handshake on either side
	localparam int HOLD_CYCLES   = 300;   // one long receiver hold-off
	localparam int SETTLE_CYCLES = 20;    // slower than the longest request latency
	localparam int FLOW_SAMPLES  = 40;    // back to back requests with the receiver always ready
	localparam int MAX_SHOWN     = 40;    // mismatch lines printed before going quiet

	// index that maps to no register; writes to it must change nothing
	localparam logic [gsm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// one result as it leaves the block
	typedef struct packed {
		logic [1:0]                 st;
		gsm_pkg::sample_t           mx;
		gsm_pkg::sample_t           my;
		gsm_pkg::sample_t           mz;
		logic [gsm_pkg::FILL_W-1:0] fill;
		logic [gsm_pkg::CNT_W-1:0]  det;
		logic                       conf;
	} fix_t;

	// receiver stall styles
	typedef enum {RX_FLOW, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

	// tracks the filter state and the queue of fixes still owed by the block
	class track_predictor;
		logic [gsm_pkg::LIM_W-1:0] range_lim;
		logic [gsm_pkg::LIM_W-1:0] dev_lim;
		logic [gsm_pkg::MIN_W-1:0] min_det;
		int win [3][gsm_pkg::WINDOW_DEPTH];
		int head;
		int fill;
		int hits;
		bit seen;
		int held [3];
		fix_t pending_fixes [$];
		int errors;

		function new();
			range_lim = gsm_pkg::RANGE_RESET;
			dev_lim = gsm_pkg::THR_RESET;
			min_det = gsm_pkg::MIN_RESET;
			head = 0;
			fill = 0;
			hits = 0;
			seen = 1'b0;
			held = '{0, 0, 0};
			errors = 0;
		endfunction

		function void write_reg(logic [gsm_pkg::CFG_IDX_W-1:0] idx,
				logic [gsm_pkg::CFG_W-1:0] data);
			case (idx)
			gsm_pkg::REG_RANGE_LIMIT: range_lim = data[gsm_pkg::LIM_W-1:0];
			gsm_pkg::REG_OUTLIER_THR: dev_lim = data[gsm_pkg::LIM_W-1:0];
			gsm_pkg::REG_MIN_DET: min_det = data[gsm_pkg::MIN_W-1:0];
			default: ;
			endcase
		endfunction

		function int magnitude(int v);
			return (v < 0) ? -v : v;
		endfunction

		// median of one axis over the held samples, floor of the mean for even fill
		function int axis_median(int a);
			int vals [gsm_pkg::WINDOW_DEPTH];
			int i;
			int j;
			int t;
			for (i = 0; i < fill; i++) begin
				t = win[a][(head + i) % gsm_pkg::WINDOW_DEPTH];
				j = i;
				while (j > 0 && vals[j - 1] > t) begin
					vals[j] = vals[j - 1];
					j--;
				end
				vals[j] = t;
			end
			if (fill == 0)
				return 0;
			if (fill % 2)
				return vals[fill / 2];
			return (vals[fill / 2 - 1] + vals[fill / 2]) >>> 1;
		endfunction

		function void take_request(logic clr, gsm_pkg::sample_t px, gsm_pkg::sample_t py,
				gsm_pkg::sample_t pz);
			int v [3];
			int a;
			int slot;
			bit far;
			bit outl;
			fix_t want;
			if (clr) begin
				fill = 0;
				head = 0;
				hits = 0;
				seen = 1'b0;
				want.st = gsm_pkg::STAT_CLEARED;
			end else begin
				v[0] = px;
				v[1] = py;
				v[2] = pz;
				far = 1'b0;
				outl = 1'b0;
				for (a = 0; a < 3; a++)
					if (magnitude(v[a]) > int'(range_lim))
						far = 1'b1;
				if (!far && fill >= gsm_pkg::OUTL_MIN_FILL)
					for (a = 0; a < 3; a++)
						if (magnitude(v[a] - held[a]) > int'(dev_lim))
							outl = 1'b1;
				if (far) begin
					want.st = gsm_pkg::STAT_FAR;
				end else if (outl) begin
					want.st = gsm_pkg::STAT_OUTLIER;
				end else begin
					if (fill >= gsm_pkg::WINDOW_DEPTH) begin
						slot = head;
						head = (head + 1) % gsm_pkg::WINDOW_DEPTH;
					end else begin
						slot = (head + fill) % gsm_pkg::WINDOW_DEPTH;
						fill++;
					end
					for (a = 0; a < 3; a++)
						win[a][slot] = v[a];
					for (a = 0; a < 3; a++)
						held[a] = axis_median(a);
					if (hits < (1 << gsm_pkg::CNT_W) - 1)
						hits++;
					seen = 1'b1;
					want.st = gsm_pkg::STAT_ACCEPTED;
				end
			end
			want.mx = gsm_pkg::sample_t'(held[0]);
			want.my = gsm_pkg::sample_t'(held[1]);
			want.mz = gsm_pkg::sample_t'(held[2]);
			want.fill = gsm_pkg::FILL_W'(fill);
			want.det = gsm_pkg::CNT_W'(hits);
			want.conf = seen && (hits >= int'(min_det));
			pending_fixes = {pending_fixes, want};
		endfunction

		task report(string what);
			if (errors < MAX_SHOWN)
				$display("[%0t] mismatch: %s", $time, what);
			errors++;
		endtask

		task check_fix(fix_t got);
			fix_t want;
			if (pending_fixes.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			want = pending_fixes.pop_front();
			if (got.st !== want.st)
				report($sformatf("status got %0d want %0d", got.st, want.st));
			if (got.mx !== want.mx)
				report($sformatf("median_x got %0d want %0d", got.mx, want.mx));
			if (got.my !== want.my)
				report($sformatf("median_y got %0d want %0d", got.my, want.my));
			if (got.mz !== want.mz)
				report($sformatf("median_z got %0d want %0d", got.mz, want.mz));
			if (got.fill !== want.fill)
				report($sformatf("window_fill got %0d want %0d", got.fill, want.fill));
			if (got.det !== want.det)
				report($sformatf("detections got %0d want %0d", got.det, want.det));
			if (got.conf !== want.conf)
				report($sformatf("confirmed got %0d want %0d", got.conf, want.conf));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	gsm_pkg::sample_t sample_x = '0;
	gsm_pkg::sample_t sample_y = '0;
	gsm_pkg::sample_t sample_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	gsm_pkg::sample_t median_x;
	gsm_pkg::sample_t median_y;
	gsm_pkg::sample_t median_z;
	logic [gsm_pkg::FILL_W-1:0] window_fill;
	logic [gsm_pkg::CNT_W-1:0] detections;
	logic confirmed;
	logic cfg_we = 1'b0;
	logic [gsm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [gsm_pkg::CFG_W-1:0] cfg_data = '0;

	track_predictor sb = new();

	// receiver controls, set from the stimulus process
	bit hold_req = 1'b0;
	bit quiet_rx = 1'b0;
	int stuck_cycles = 0;

	gated_sliding_median_filter u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.sample_x(sample_x),
		.sample_y(sample_y),
		.sample_z(sample_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.median_x(median_x),
		.median_y(median_y),
		.median_z(median_z),
		.window_fill(window_fill),
		.detections(detections),
		.confirmed(confirmed),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// keep values inside the current range limit so they pass the far gate
	function automatic gsm_pkg::sample_t clamp_axis(int v);
		int lim;
		lim = int'(sb.range_lim);
		if (v > lim)
			return gsm_pkg::sample_t'(lim);
		if (v < -lim)
			return gsm_pkg::sample_t'(-lim);
		return gsm_pkg::sample_t'(v);
	endfunction

	// a value around the held median, at most spread away before clamping
	function automatic gsm_pkg::sample_t near_axis(int a, int spread);
		return clamp_axis(sb.held[a] + int'($urandom_range(2 * spread)) - spread);
	endfunction

	// a value past the range limit; at the widest limit only -32768 is too far
	function automatic gsm_pkg::sample_t over_axis();
		int v;
		if (int'(sb.range_lim) >= 32767)
			return gsm_pkg::sample_t'(-32768);
		v = $urandom_range(int'(sb.range_lim) + 1, 32767);
		return $urandom_range(1) ? gsm_pkg::sample_t'(v) : gsm_pkg::sample_t'(-v);
	endfunction

	function automatic gsm_pkg::sample_t wild_axis();
		case ($urandom_range(7))
		0: return gsm_pkg::sample_t'(-32768);
		1: return gsm_pkg::sample_t'(32767);
		2: return gsm_pkg::sample_t'(0);
		3: return gsm_pkg::sample_t'(-1);
		default: return gsm_pkg::sample_t'($urandom);
		endcase
	endfunction

	// mostly samples that track the window, with clears, noise and gate probes mixed in
	task automatic pick_request(output logic clr, output gsm_pkg::sample_t x,
			output gsm_pkg::sample_t y, output gsm_pkg::sample_t z);
		gsm_pkg::sample_t s [3];
		int r;
		int a;
		int dev;
		r = $urandom_range(99);
		a = $urandom_range(2);
		dev = int'(sb.dev_lim);
		clr = 1'b0;
		for (int i = 0; i < 3; i++)
			s[i] = near_axis(i, dev);
		if (r < 4) begin
			clr = 1'b1;
			for (int i = 0; i < 3; i++)
				s[i] = wild_axis();
		end else if (r < 12) begin
			for (int i = 0; i < 3; i++)
				s[i] = wild_axis();
		end else if (r < 22) begin
			s[a] = over_axis();
		end else if (r < 32) begin
			// right on the deviation limit or one past it
			if ($urandom_range(1))
				s[a] = clamp_axis(sb.held[a] + dev + int'($urandom_range(1)));
			else
				s[a] = clamp_axis(sb.held[a] - dev - int'($urandom_range(1)));
		end
		x = s[0];
		y = s[1];
		z = s[2];
	endtask

	// present one request and hold it until the block takes it; valid stays high
	task automatic offer(logic clr, gsm_pkg::sample_t x, gsm_pkg::sample_t y,
			gsm_pkg::sample_t z);
		in_valid <= 1'b1;
		kind <= clr;
		sample_x <= x;
		sample_y <= y;
		sample_z <= z;
		do
			@(posedge clk);
		while (in_stall);
		sb.take_request(clr, x, y, z);
	endtask

	// drop valid and wait for every owed result
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_fixes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic poke(logic [gsm_pkg::CFG_IDX_W-1:0] idx, logic [gsm_pkg::CFG_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// writes all three registers plus a stray write to the unused index
	task automatic set_config(logic [gsm_pkg::CFG_W-1:0] range_data,
			logic [gsm_pkg::CFG_W-1:0] thr_data, logic [gsm_pkg::CFG_W-1:0] min_data);
		cfg_we <= 1'b1;
		poke(gsm_pkg::REG_RANGE_LIMIT, range_data);
		poke(gsm_pkg::REG_OUTLIER_THR, thr_data);
		poke(gsm_pkg::REG_MIN_DET, min_data);
		poke(REG_UNUSED, gsm_pkg::CFG_W'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random requests in bursts of random length with random gaps between them
	task automatic run_random(int count, int hold_at);
		int burst;
		int gap;
		logic clr;
		gsm_pkg::sample_t x;
		gsm_pkg::sample_t y;
		gsm_pkg::sample_t z;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_req = 1'b1;
			if (burst == 0) begin
				burst = ($urandom_range(9) == 0) ? 40 : $urandom_range(1, 12);
				gap = $urandom_range(20);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			pick_request(clr, x, y, z);
			offer(clr, x, y, z);
			burst--;
		end
	endtask

	// results are sampled at the edge where they are taken, before any update lands
	always @(posedge clk) begin : result_side
		fix_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status, median_x, median_y, median_z, window_fill, detections,
				confirmed};
			sb.check_fix(got);
		end
	end

	// receiver: stall style changes per segment, with one long hold-off on request
	initial begin : rx_side
		rx_mode_t mode;
		int span;
		int period;
		int duty;
		forever begin
			if (hold_req) begin
				repeat (HOLD_CYCLES) begin
					@(posedge clk);
					out_stall <= 1'b1;
				end
				hold_req = 1'b0;
			end
			mode = quiet_rx ? RX_FLOW : rx_mode_t'($urandom_range(3));
			span = $urandom_range(5, 80);
			period = $urandom_range(2, 9);
			duty = $urandom_range(1, period - 1);
			for (int i = 0; i < span; i++) begin
				@(posedge clk);
				case (mode)
				RX_FLOW: out_stall <= 1'b0;
				RX_COIN: out_stall <= ($urandom_range(1) == 0);
				RX_SPARSE: out_stall <= ($urandom_range(4) == 0);
				default: out_stall <= ((i % period) < duty);
				endcase
			end
		end
	end

	// watchdog: too long without a handshake on either channel ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int dev;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset register values
		dev = int'(sb.dev_lim);
		offer(1'b1, '0, '0, '0);              // clear on an empty window
		offer(1'b0, gsm_pkg::sample_t'(10000), gsm_pkg::sample_t'(-10000), '0);
		offer(1'b0, gsm_pkg::sample_t'(10001), '0, '0);    // one past the limit on x
		offer(1'b0, '0, '0, gsm_pkg::sample_t'(-10001));   // one past the limit on z
		offer(1'b0, gsm_pkg::sample_t'(-32768), '0, '0);   // most negative is always too far
		// even fill, floor of a negative mean on y
		offer(1'b0, gsm_pkg::sample_t'(1), gsm_pkg::sample_t'(-1), gsm_pkg::sample_t'(7));
		// no outlier gate below three samples
		offer(1'b0, gsm_pkg::sample_t'(-9000), gsm_pkg::sample_t'(9000),
			gsm_pkg::sample_t'(-9000));
		// deviation gate now active; exactly at the threshold passes
		offer(1'b0, gsm_pkg::sample_t'(sb.held[0] + dev), gsm_pkg::sample_t'(sb.held[1] - dev),
			gsm_pkg::sample_t'(sb.held[2]));
		offer(1'b0, gsm_pkg::sample_t'(sb.held[0] + dev + 1), gsm_pkg::sample_t'(sb.held[1]),
			gsm_pkg::sample_t'(sb.held[2]));
		offer(1'b0, gsm_pkg::sample_t'(sb.held[0]), gsm_pkg::sample_t'(sb.held[1]),
			gsm_pkg::sample_t'(sb.held[2] - dev - 1));
		offer(1'b0, gsm_pkg::sample_t'(sb.held[0]), gsm_pkg::sample_t'(sb.held[1] - dev - 1),
			gsm_pkg::sample_t'(sb.held[2]));
		// fill past the window depth so the oldest entries wrap out
		repeat (11)
			offer(1'b0, near_axis(0, dev / 4), near_axis(1, dev / 4), near_axis(2, dev / 4));
		offer(1'b1, '1, '1, '1);              // clear keeps the held medians
		offer(1'b0, gsm_pkg::sample_t'(32767), gsm_pkg::sample_t'(-32768),
			gsm_pkg::sample_t'(32767));
		// first accepted sample after a clear
		offer(1'b0, gsm_pkg::sample_t'(-5), gsm_pkg::sample_t'(5), gsm_pkg::sample_t'(-5));

		run_random(300, -1);

		// widest range via a write with the top data bit set, zero threshold, zero minimum;
		// the long receiver hold-off lands in this phase
		drain();
		set_config(16'hFFFF, 16'h0000, 16'h0000);
		run_random(200, 50);

		// zero range: only the origin gets through
		drain();
		set_config(16'h0000, 16'h7FFF, 16'h0001);
		run_random(100, -1);

		repeat (4) begin
			drain();
			set_config({1'($urandom_range(1)), 15'($urandom_range(500, 32767))},
				{1'($urandom_range(1)), 15'($urandom_range(5000))},
				gsm_pkg::CFG_W'($urandom_range(12)));
			run_random(160, -1);
		end

		// back to back with no receiver stalls; a minimum this high never confirms
		drain();
		set_config(16'h7FFF, 16'h7FFF, 16'hFFFF);
		quiet_rx = 1'b1;
		offer(1'b1, '0, '0, '0);
		repeat (FLOW_SAMPLES)
			offer(1'b0, gsm_pkg::sample_t'(int'($urandom_range(200)) - 100),
				gsm_pkg::sample_t'(int'($urandom_range(200)) - 100),
				gsm_pkg::sample_t'(int'($urandom_range(200)) - 100));
		offer(1'b1, '0, '0, '0);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
